@@ design/qbs_pkg.sv @@
`timescale 1ns / 1ps

package qbs_pkg;

  // segments per curve
  localparam int STEPS    = 10;
  localparam int SQ       = STEPS * STEPS;
  localparam int DIV      = 16 * SQ;

  // field widths
  localparam int C_W      = 16;
  localparam int P_W      = 12;
  localparam int K_W      = $clog2(STEPS + 1);
  localparam int W_W      = $clog2(SQ + 1);

  // datapath widths of the coordinate lane
  localparam int PROD_W   = C_W + W_W + 1;
  localparam int MAG_W    = 16 + $clog2(SQ);
  localparam int NUM_W    = MAG_W + 1;
  localparam int SH       = MAG_W;
  localparam int RECIP    = (1 << SH) / DIV;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int Q_W      = P_W + 1;

  // register stages inside one coordinate lane
  localparam int LANE_LAT = 5;

  typedef struct packed {
    logic                  action;
    logic signed [C_W-1:0] start_px;
    logic signed [C_W-1:0] start_py;
    logic signed [C_W-1:0] ctrl_px;
    logic signed [C_W-1:0] ctrl_py;
    logic signed [C_W-1:0] end_px;
    logic signed [C_W-1:0] end_py;
    logic signed [C_W-1:0] fan_x;
    logic signed [C_W-1:0] fan_y;
    logic        [15:0]    pen_color;
  } qbs_in_t;

  typedef struct packed {
    logic signed [P_W-1:0] seg_x0;
    logic signed [P_W-1:0] seg_y0;
    logic signed [P_W-1:0] seg_x1;
    logic signed [P_W-1:0] seg_y1;
    logic signed [P_W-1:0] apex_x;
    logic signed [P_W-1:0] apex_y;
    logic                  draw_kind;
    logic        [15:0]    seg_color;
    logic                  last_seg;
  } qbs_out_t;

  // blend weights of one step
  typedef struct packed {
    logic [W_W-1:0] wa;
    logic [W_W-1:0] wb;
    logic [W_W-1:0] wc;
  } qbs_wt_t;

  // per-segment data that bypasses the arithmetic
  typedef struct packed {
    logic                  first;
    logic                  last;
    logic signed [P_W-1:0] sx;
    logic signed [P_W-1:0] sy;
    logic signed [P_W-1:0] apx;
    logic signed [P_W-1:0] apy;
    logic                  kind;
    logic        [15:0]    color;
  } qbs_side_t;

  // one segment request issued by the sequencer
  typedef struct packed {
    logic                  valid;
    qbs_wt_t               wt;
    logic signed [C_W-1:0] ax;
    logic signed [C_W-1:0] bx;
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] ay;
    logic signed [C_W-1:0] by;
    logic signed [C_W-1:0] cy;
    qbs_side_t             side;
  } qbs_issue_t;

endpackage

@@ design/qbs_seq.sv @@
`timescale 1ns / 1ps

module qbs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  qbs_pkg::qbs_in_t    in_data,
  output logic                in_stall,
  output qbs_pkg::qbs_issue_t issue
);
  import qbs_pkg::*;

  // held curve
  logic signed [C_W-1:0] ax_r, bx_r, cx_r, ay_r, by_r, cy_r;
  logic signed [P_W-1:0] sx_r, sy_r, apx_r, apy_r;
  logic                  kind_r;
  logic        [15:0]    color_r;

  logic                  busy_r;
  logic [K_W-1:0]        k_r;
  qbs_issue_t            issue_r;

  logic                  at_last;
  logic                  accept;
  qbs_issue_t            issue_nxt;

  // bezier blend weights (S-k)^2, 2k(S-k), k^2
  function automatic qbs_wt_t step_weights(input logic [K_W-1:0] k);
    int      kk;
    int      rr;
    qbs_wt_t w;
    kk   = int'(k);
    rr   = STEPS - kk;
    w.wa = W_W'(rr * rr);
    w.wb = W_W'(2 * kk * rr);
    w.wc = W_W'(kk * kk);
    return w;
  endfunction

  // q12.4 to whole pixels, truncated toward zero
  function automatic logic signed [P_W-1:0] to_pixel(input logic signed [C_W-1:0] v);
    logic signed [C_W:0] t;
    t = {v[C_W-1], v} + (v[C_W-1] ? (C_W+1)'(15) : (C_W+1)'(0));
    return t[P_W+3:4];
  endfunction

  assign at_last  = (k_r == K_W'(STEPS));
  assign in_stall = busy_r && !(en && at_last);
  assign accept   = in_valid && !in_stall;

  // next issued segment
  always_comb begin
    issue_nxt            = '0;
    issue_nxt.valid      = busy_r;
    issue_nxt.wt         = step_weights(k_r);
    issue_nxt.ax         = ax_r;
    issue_nxt.bx         = bx_r;
    issue_nxt.cx         = cx_r;
    issue_nxt.ay         = ay_r;
    issue_nxt.by         = by_r;
    issue_nxt.cy         = cy_r;
    issue_nxt.side.first = (k_r == K_W'(1));
    issue_nxt.side.last  = at_last;
    issue_nxt.side.sx    = sx_r;
    issue_nxt.side.sy    = sy_r;
    issue_nxt.side.apx   = apx_r;
    issue_nxt.side.apy   = apy_r;
    issue_nxt.side.kind  = kind_r;
    issue_nxt.side.color = color_r;
  end

  // step counter and issue register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      k_r           <= '0;
      issue_r.valid <= 1'b0;
    end else begin
      if (en) begin
        issue_r <= issue_nxt;
        if (busy_r) begin
          if (at_last) begin
            busy_r <= 1'b0;
            k_r    <= '0;
          end else begin
            k_r <= k_r + K_W'(1);
          end
        end
      end
      if (accept) begin
        busy_r <= 1'b1;
        k_r    <= K_W'(1);
      end
    end
  end

  // capture a new curve
  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r    <= in_data.start_px;
      ay_r    <= in_data.start_py;
      bx_r    <= in_data.ctrl_px;
      by_r    <= in_data.ctrl_py;
      cx_r    <= in_data.end_px;
      cy_r    <= in_data.end_py;
      sx_r    <= to_pixel(in_data.start_px);
      sy_r    <= to_pixel(in_data.start_py);
      apx_r   <= in_data.action ? to_pixel(in_data.fan_x) : '0;
      apy_r   <= in_data.action ? to_pixel(in_data.fan_y) : '0;
      kind_r  <= in_data.action;
      color_r <= in_data.pen_color;
    end
  end

  assign issue = issue_r;

endmodule

@@ design/qbs_coord_lane.sv @@
`timescale 1ns / 1ps

module qbs_coord_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qbs_pkg::C_W-1:0] a,
  input  logic signed [qbs_pkg::C_W-1:0] b,
  input  logic signed [qbs_pkg::C_W-1:0] c,
  input  qbs_pkg::qbs_wt_t              wt,
  output logic signed [qbs_pkg::P_W-1:0] pt
);
  import qbs_pkg::*;

  // stage b: weighted products
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r;
  logic signed [PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt;

  // stage c: sign and magnitude of the numerator
  logic signed [PROD_W+1:0] sum;
  logic [NUM_W-1:0]         num;
  logic [MAG_W-1:0]         mag_c_r, mag_c_nxt;
  logic                     neg_c_r;

  // stage d: reciprocal product
  logic [MAG_W+RECIP_W-1:0] rp_r;
  logic [MAG_W-1:0]         mag_d_r;
  logic                     neg_d_r;

  // stage e: quotient estimate and its back product
  logic [Q_W-1:0]           qe_nxt, qe_r;
  logic [MAG_W-1:0]         qd_nxt, qd_r;
  logic [MAG_W-1:0]         mag_e_r;
  logic                     neg_e_r;

  // stage f: correction and sign
  logic [MAG_W-1:0]         rem;
  logic [Q_W-1:0]           q;
  logic [Q_W-1:0]           qn;
  logic signed [P_W-1:0]    pt_r;

  assign pa_nxt = PROD_W'($signed({1'b0, wt.wa})) * PROD_W'(a);
  assign pb_nxt = PROD_W'($signed({1'b0, wt.wb})) * PROD_W'(b);
  assign pc_nxt = PROD_W'($signed({1'b0, wt.wc})) * PROD_W'(c);

  assign sum       = (PROD_W+2)'(pa_r) + (PROD_W+2)'(pb_r) + (PROD_W+2)'(pc_r);
  assign num       = sum[NUM_W-1:0];
  assign mag_c_nxt = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

  // estimate and its back product belong to the same segment
  assign qe_nxt = rp_r[SH+Q_W-1:SH];
  assign qd_nxt = MAG_W'(qe_nxt * DIV);

  // estimate is low by at most one
  assign rem = mag_e_r - qd_r;
  assign q   = qe_r + Q_W'(rem >= MAG_W'(DIV));
  assign qn  = neg_e_r ? -q : q;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      mag_c_r <= mag_c_nxt;
      neg_c_r <= num[NUM_W-1];
      rp_r    <= (MAG_W+RECIP_W)'(mag_c_r) * (MAG_W+RECIP_W)'(RECIP);
      mag_d_r <= mag_c_r;
      neg_d_r <= neg_c_r;
      qe_r    <= qe_nxt;
      qd_r    <= qd_nxt;
      mag_e_r <= mag_d_r;
      neg_e_r <= neg_d_r;
      pt_r    <= qn[P_W-1:0];
    end
  end

  assign pt = pt_r;

endmodule

@@ design/quadratic_bezier_segmenter.sv @@
`timescale 1ns / 1ps

// Quadratic Bezier segmenter. Each request on the input channel is one curve
// (three Q12.4 control points, an anchor, a colour and a line/fan action); the
// block returns STEPS segments (ten) at t = k/STEPS, in order, the last one
// flagged and ending exactly on the end point, coordinates truncated toward
// zero to whole pixels. A sequencer issues one segment per cycle, while the
// output is not stalled, into two coordinate lanes of five register stages
// each (products, sum, reciprocal multiply, back product, correction), with
// no gap between curves: the next curve is accepted in the cycle its
// predecessor's last segment is issued. The first segment of a curve passes
// through the issue register, both lanes and the output register. A stall
// on the output freezes the whole pipe and loses nothing.
module quadratic_bezier_segmenter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qbs_pkg::qbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qbs_pkg::qbs_out_t out_data
);
  import qbs_pkg::*;

  logic                  en;
  qbs_issue_t            issue;
  logic signed [P_W-1:0] pt_x, pt_y;

  logic                  side_v_r [LANE_LAT];
  qbs_side_t             side_r   [LANE_LAT];

  logic                  out_valid_r;
  qbs_out_t              out_r;
  logic signed [P_W-1:0] prev_x_r, prev_y_r;
  qbs_side_t             side_o;

  // whole pipe advances when the output register is free or being taken
  assign en = !out_valid_r || !out_stall;

  qbs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .issue    (issue)
  );

  qbs_coord_lane u_lane_x (
    .clk (clk),
    .en  (en),
    .a   (issue.ax),
    .b   (issue.bx),
    .c   (issue.cx),
    .wt  (issue.wt),
    .pt  (pt_x)
  );

  qbs_coord_lane u_lane_y (
    .clk (clk),
    .en  (en),
    .a   (issue.ay),
    .b   (issue.by),
    .c   (issue.cy),
    .wt  (issue.wt),
    .pt  (pt_y)
  );

  // valid bits alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        side_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      side_v_r[0] <= issue.valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_v_r[i] <= side_v_r[i-1];
      end
    end
  end

  // sideband data alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= issue.side;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign side_o = side_r[LANE_LAT-1];

  // output register and previous point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else if (en) begin
      out_valid_r <= side_v_r[LANE_LAT-1];
      if (side_v_r[LANE_LAT-1]) begin
        prev_x_r <= pt_x;
        prev_y_r <= pt_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && side_v_r[LANE_LAT-1]) begin
      out_r.seg_x0    <= side_o.first ? side_o.sx : prev_x_r;
      out_r.seg_y0    <= side_o.first ? side_o.sy : prev_y_r;
      out_r.seg_x1    <= pt_x;
      out_r.seg_y1    <= pt_y;
      out_r.apex_x    <= side_o.apx;
      out_r.apex_y    <= side_o.apy;
      out_r.draw_kind <= side_o.kind;
      out_r.seg_color <= side_o.color;
      out_r.last_seg  <= side_o.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/qbs_checker.sv @@
`timescale 1ns / 1ps

module qbs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input qbs_pkg::qbs_out_t out_data
);
  import qbs_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a curve keeps the input stalled while its segments are issued
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (STEPS > 1) && in_acc |=> in_stall)
    else $error("new request taken while curve in progress");

  // two final segments never follow each other
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (STEPS > 1) && out_acc && out_data.last_seg |=> !(out_valid && out_data.last_seg))
    else $error("back-to-back final segments");

  // outline mode carries a zero anchor
  a_apex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.draw_kind |-> out_data.apex_x == '0 && out_data.apex_y == '0)
    else $error("anchor not zero in outline mode");

endmodule

bind quadratic_bezier_segmenter qbs_checker u_qbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ sim/quadratic_bezier_segmenter_tb.sv @@
`timescale 1ns / 1ps

module quadratic_bezier_segmenter_tb;
  import qbs_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 30;

  // segments still owed by the block, built from every accepted curve request
  class segment_ledger;
    qbs_out_t pending_segs[$];
    int       fails;
    int       shown;

    // one coordinate of point k, exact integer blend, truncated toward zero
    function logic [P_W-1:0] blend_point(longint a, longint b, longint c, int k);
      longint r;
      longint num;
      r   = STEPS - k;
      num = r * r * a + 2 * k * r * b + k * k * c;
      return P_W'(num / DIV);
    endfunction

    // flatten one curve into its STEPS segments
    function void note_curve(qbs_in_t c);
      longint   x0, y0, x1, y1, x2, y2;
      logic [P_W-1:0] px, py, nx, ny, ax, ay;
      qbs_out_t seg;
      x0 = longint'($signed(c.start_px));
      y0 = longint'($signed(c.start_py));
      x1 = longint'($signed(c.ctrl_px));
      y1 = longint'($signed(c.ctrl_py));
      x2 = longint'($signed(c.end_px));
      y2 = longint'($signed(c.end_py));
      // apex only means something in fan mode
      ax = c.action ? P_W'(longint'($signed(c.fan_x)) / 16) : '0;
      ay = c.action ? P_W'(longint'($signed(c.fan_y)) / 16) : '0;
      px = P_W'(x0 / 16);
      py = P_W'(y0 / 16);
      for (int k = 1; k <= STEPS; k++) begin
        nx = blend_point(x0, x1, x2, k);
        ny = blend_point(y0, y1, y2, k);
        seg.seg_x0    = px;
        seg.seg_y0    = py;
        seg.seg_x1    = nx;
        seg.seg_y1    = ny;
        seg.apex_x    = ax;
        seg.apex_y    = ay;
        seg.draw_kind = c.action;
        seg.seg_color = c.pen_color;
        seg.last_seg  = (k == STEPS);
        pending_segs.push_back(seg);
        px = nx;
        py = ny;
      end
    endfunction

    // compare one delivered segment with the oldest one owed
    function void check_segment(qbs_out_t got);
      qbs_out_t want;
      if (pending_segs.size() == 0) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("unexpected segment: (%0d,%0d)-(%0d,%0d)", got.seg_x0, got.seg_y0,
                   got.seg_x1, got.seg_y1);
        end
        return;
      end
      want = pending_segs.pop_front();
      if (got.seg_x0 !== want.seg_x0 || got.seg_y0 !== want.seg_y0 ||
          got.seg_x1 !== want.seg_x1 || got.seg_y1 !== want.seg_y1 ||
          got.apex_x !== want.apex_x || got.apex_y !== want.apex_y ||
          got.draw_kind !== want.draw_kind || got.seg_color !== want.seg_color ||
          got.last_seg !== want.last_seg) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("expected (%0d,%0d)-(%0d,%0d) apex (%0d,%0d) kind %0d col %h last %0d",
                   want.seg_x0, want.seg_y0, want.seg_x1, want.seg_y1, want.apex_x,
                   want.apex_y, want.draw_kind, want.seg_color, want.last_seg);
          $display("actual   (%0d,%0d)-(%0d,%0d) apex (%0d,%0d) kind %0d col %h last %0d",
                   got.seg_x0, got.seg_y0, got.seg_x1, got.seg_y1, got.apex_x,
                   got.apex_y, got.draw_kind, got.seg_color, got.last_seg);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  qbs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qbs_out_t out_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;

  segment_ledger ledger;

  quadratic_bezier_segmenter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) ledger.check_segment(out_data);
      if (in_valid && !in_stall) ledger.note_curve(in_data);
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic qbs_in_t make_curve(input logic act,
                                         input logic [15:0] sx, sy, cx, cy, ex, ey, fx, fy,
                                         input logic [15:0] col);
    qbs_in_t c;
    c.action    = act;
    c.start_px  = sx;
    c.start_py  = sy;
    c.ctrl_px   = cx;
    c.ctrl_py   = cy;
    c.end_px    = ex;
    c.end_py    = ey;
    c.fan_x     = fx;
    c.fan_y     = fy;
    c.pen_color = col;
    return c;
  endfunction

  // mix of near-origin, near-extreme and full-range coordinates
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(4095)) - 16'd2048;
      1: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(15))
                                  : 16'h8000 + 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qbs_in_t random_curve();
    return make_curve(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      16'($urandom));
  endfunction

  // offer one curve request, called and returning at a falling edge
  task automatic push_curve(input qbs_in_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) push_curve(random_curve());
  endtask

  // hold the sender back until every owed segment has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.pending_segs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    ledger = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed curves: extremes, both actions, truncation near zero
    push_curve(make_curve(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000));
    push_curve(make_curve(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'hffff));
    push_curve(make_curve(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h0000));
    // line mode with a live anchor: apex must read zero
    push_curve(make_curve(1'b0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                          16'h1234, 16'h4321, 16'haaaa));
    push_curve(make_curve(1'b1, 16'hffff, 16'hfff1, 16'hffef, 16'h0011, 16'hfff0, 16'h000f,
                          16'hffef, 16'hffff, 16'h5555));
    push_curve(make_curve(1'b0, 16'h0000, 16'h0000, 16'h0320, 16'h0000, 16'h0640, 16'h0000,
                          16'h0000, 16'h0000, 16'hf800));
    // closed curve: final segment must land back on the start
    push_curve(make_curve(1'b1, 16'h1000, 16'hf000, 16'h8000, 16'h7fff, 16'h1000, 16'hf000,
                          16'h8000, 16'h7fff, 16'h07e0));
    push_curve(make_curve(1'b1, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010,
                          16'h7ff0, 16'h8010, 16'h001f));
    push_curve(make_curve(1'b0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff,
                          16'h0000, 16'h0000, 16'hffff));
    push_curve(make_curve(1'b1, 16'h0001, 16'hffff, 16'h0002, 16'hfffe, 16'h0003, 16'hfffd,
                          16'h0001, 16'hffff, 16'h8001));
    wait_drained();

    // sender idles lightly, receiver heavily
    tx_idle_pct = 20;
    rx_idle_pct = 71;
    push_random(110);
    wait_drained();

    // long receiver hold-off while requests keep coming, so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= ~hold_req;
    push_random(20);

    // receiver idles lightly, sender heavily
    tx_idle_pct = 71;
    rx_idle_pct = 20;
    push_random(100);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random(90);
    in_valid <= 1'b0;

    while (ledger.pending_segs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.fails == 0 && ledger.pending_segs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
